[rtl/fpca_pkg.sv]
// Shared types, codes and defaults for the fit-policy chunk allocator.
`timescale 1ns / 1ps

package fpca_pkg;

    // Default sizing of the chunk table and byte buffer
    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int MAX_CHUNKS_DEF   = 64;

    // Fixed field widths of the transaction payloads
    localparam int SIZE_W  = 11;
    localparam int INDEX_W = 6;
    localparam int OFFS_W  = 10;
    localparam int FREE_W  = 11;
    localparam int REF_W   = 32;

    typedef logic [SIZE_W-1:0]  item_size_t;
    typedef logic [INDEX_W-1:0] chunk_index_t;
    typedef logic [OFFS_W-1:0]  byte_offset_t;
    typedef logic [FREE_W-1:0]  free_t;
    typedef logic [REF_W-1:0]   refused_t;

    // Placement policy register
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } policy_t;

    localparam policy_t POLICY_RESET = FIT_WORST;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // Input item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic       kind;
        item_size_t item_size;
    } in_item_t;

    typedef struct packed {
        status_t      status;
        chunk_index_t chunk_index;
        byte_offset_t byte_offset;
        free_t        total_free;
        free_t        largest_free;
        refused_t     refused_total;
    } out_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SCAN   = 3'd1,
        S_DRAIN  = 3'd2,
        S_DECIDE = 3'd3,
        S_RESULT = 3'd4
    } seq_state_t;

    // Sequencer to scan unit control
    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctl_t;

endpackage

[rtl/fpca_mem.sv]
// Chunk table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module fpca_mem #(
    parameter int  DEPTH  = 64,
    parameter int  WIDTH  = 22,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fpca_scan.sv]
// Scan unit: compares one table entry a cycle and keeps the fit candidates.
`timescale 1ns / 1ps

module fpca_scan #(
    parameter int  BUFFER_BYTES = fpca_pkg::BUFFER_BYTES_DEF,
    parameter int  MAX_CHUNKS   = fpca_pkg::MAX_CHUNKS_DEF,
    localparam int IDX_W        = $clog2(MAX_CHUNKS),
    localparam int ROOM_W       = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpca_pkg::policy_t    policy,
    input  fpca_pkg::scan_ctl_t  ctl,
    input  logic [IDX_W-1:0]     eval_idx,
    input  logic [IDX_W-1:0]     start_idx,
    input  logic [2*ROOM_W-1:0]  eval_entry,
    input  fpca_pkg::item_size_t size,
    output logic                 pick_found,
    output logic [IDX_W-1:0]     pick_idx,
    output logic [ROOM_W-1:0]    pick_room,
    output logic [ROOM_W-1:0]    pick_offset,
    output logic [ROOM_W-1:0]    top1_room,
    output logic [IDX_W-1:0]     top1_idx,
    output logic [ROOM_W-1:0]    top2_room
);

    localparam int CMP_W = (ROOM_W > fpca_pkg::SIZE_W) ? ROOM_W : fpca_pkg::SIZE_W;

    logic [ROOM_W-1:0] eval_room;
    logic [ROOM_W-1:0] eval_offset;
    logic              fits;
    logic              ext_better;

    // Lowest fitting entry
    logic              first_found_reg, first_found_next;
    logic [IDX_W-1:0]  first_idx_reg, first_idx_next;
    logic [ROOM_W-1:0] first_room_reg, first_room_next;
    logic [ROOM_W-1:0] first_off_reg, first_off_next;
    // Lowest fitting entry at or after the rover
    logic              from_found_reg, from_found_next;
    logic [IDX_W-1:0]  from_idx_reg, from_idx_next;
    logic [ROOM_W-1:0] from_room_reg, from_room_next;
    logic [ROOM_W-1:0] from_off_reg, from_off_next;
    // Smallest or largest fitting entry
    logic              ext_found_reg, ext_found_next;
    logic [IDX_W-1:0]  ext_idx_reg, ext_idx_next;
    logic [ROOM_W-1:0] ext_room_reg, ext_room_next;
    logic [ROOM_W-1:0] ext_off_reg, ext_off_next;
    // Two largest rooms overall
    logic [ROOM_W-1:0] top1_room_reg, top1_room_next;
    logic [IDX_W-1:0]  top1_idx_reg, top1_idx_next;
    logic [ROOM_W-1:0] top2_room_reg, top2_room_next;

    assign eval_room   = eval_entry[ROOM_W-1:0];
    assign eval_offset = eval_entry[2*ROOM_W-1:ROOM_W];

    // Compare and update
    always_comb begin
        fits       = CMP_W'(eval_room) >= CMP_W'(size);
        ext_better = !ext_found_reg ||
                     ((policy == fpca_pkg::FIT_BEST) ? (eval_room < ext_room_reg)
                                                     : (eval_room > ext_room_reg));

        first_found_next = first_found_reg;
        first_idx_next   = first_idx_reg;
        first_room_next  = first_room_reg;
        first_off_next   = first_off_reg;
        from_found_next  = from_found_reg;
        from_idx_next    = from_idx_reg;
        from_room_next   = from_room_reg;
        from_off_next    = from_off_reg;
        ext_found_next   = ext_found_reg;
        ext_idx_next     = ext_idx_reg;
        ext_room_next    = ext_room_reg;
        ext_off_next     = ext_off_reg;
        top1_room_next   = top1_room_reg;
        top1_idx_next    = top1_idx_reg;
        top2_room_next   = top2_room_reg;

        if (ctl.clear) begin
            first_found_next = 1'b0;
            from_found_next  = 1'b0;
            ext_found_next   = 1'b0;
            top1_room_next   = '0;
            top1_idx_next    = '0;
            top2_room_next   = '0;
        end else if (ctl.eval) begin
            if (fits && !first_found_reg) begin
                first_found_next = 1'b1;
                first_idx_next   = eval_idx;
                first_room_next  = eval_room;
                first_off_next   = eval_offset;
            end
            if (fits && !from_found_reg && (eval_idx >= start_idx)) begin
                from_found_next = 1'b1;
                from_idx_next   = eval_idx;
                from_room_next  = eval_room;
                from_off_next   = eval_offset;
            end
            if (fits && ext_better) begin
                ext_found_next = 1'b1;
                ext_idx_next   = eval_idx;
                ext_room_next  = eval_room;
                ext_off_next   = eval_offset;
            end
            if (eval_room > top1_room_reg) begin
                top2_room_next = top1_room_reg;
                top1_room_next = eval_room;
                top1_idx_next  = eval_idx;
            end else if (eval_room > top2_room_reg) begin
                top2_room_next = eval_room;
            end
        end
    end

    // Candidate registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_found_reg <= 1'b0;
            from_found_reg  <= 1'b0;
            ext_found_reg   <= 1'b0;
        end else begin
            first_found_reg <= first_found_next;
            from_found_reg  <= from_found_next;
            ext_found_reg   <= ext_found_next;
        end
        first_idx_reg  <= first_idx_next;
        first_room_reg <= first_room_next;
        first_off_reg  <= first_off_next;
        from_idx_reg   <= from_idx_next;
        from_room_reg  <= from_room_next;
        from_off_reg   <= from_off_next;
        ext_idx_reg    <= ext_idx_next;
        ext_room_reg   <= ext_room_next;
        ext_off_reg    <= ext_off_next;
        top1_room_reg  <= top1_room_next;
        top1_idx_reg   <= top1_idx_next;
        top2_room_reg  <= top2_room_next;
    end

    // Policy select; next fit wraps to the lowest fit when nothing follows the rover
    always_comb begin
        case (policy)
            fpca_pkg::FIT_FIRST: begin
                pick_found  = first_found_reg;
                pick_idx    = first_idx_reg;
                pick_room   = first_room_reg;
                pick_offset = first_off_reg;
            end
            fpca_pkg::FIT_NEXT: begin
                if (from_found_reg) begin
                    pick_found  = 1'b1;
                    pick_idx    = from_idx_reg;
                    pick_room   = from_room_reg;
                    pick_offset = from_off_reg;
                end else begin
                    pick_found  = first_found_reg;
                    pick_idx    = first_idx_reg;
                    pick_room   = first_room_reg;
                    pick_offset = first_off_reg;
                end
            end
            default: begin
                pick_found  = ext_found_reg;
                pick_idx    = ext_idx_reg;
                pick_room   = ext_room_reg;
                pick_offset = ext_off_reg;
            end
        endcase
    end

    assign top1_room = top1_room_reg;
    assign top1_idx  = top1_idx_reg;
    assign top2_room = top2_room_reg;

endmodule

[rtl/fpca_seq.sv]
// Sequencer: handshakes, table scan control, allocator state and result register.
`timescale 1ns / 1ps

module fpca_seq #(
    parameter int  BUFFER_BYTES = fpca_pkg::BUFFER_BYTES_DEF,
    parameter int  MAX_CHUNKS   = fpca_pkg::MAX_CHUNKS_DEF,
    localparam int IDX_W        = $clog2(MAX_CHUNKS),
    localparam int CNT_W        = $clog2(MAX_CHUNKS + 1),
    localparam int ROOM_W       = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input transactions
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fpca_pkg::in_item_t   s_data,
    // result transactions
    output logic                 m_valid,
    input  logic                 m_ready,
    output fpca_pkg::out_item_t  m_data,
    // scan unit
    output fpca_pkg::scan_ctl_t  scan_ctl,
    output logic [IDX_W-1:0]     eval_idx,
    output logic [IDX_W-1:0]     start_idx,
    output fpca_pkg::item_size_t size,
    input  logic                 pick_found,
    input  logic [IDX_W-1:0]     pick_idx,
    input  logic [ROOM_W-1:0]    pick_room,
    input  logic [ROOM_W-1:0]    pick_offset,
    input  logic [ROOM_W-1:0]    top1_room,
    input  logic [IDX_W-1:0]     top1_idx,
    input  logic [ROOM_W-1:0]    top2_room,
    // table memory
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output logic [2*ROOM_W-1:0]  mem_wr_data,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr
);

    localparam int WIDE_W = ((ROOM_W > fpca_pkg::SIZE_W) ? ROOM_W : fpca_pkg::SIZE_W) + 1;
    localparam int SUM_W  = fpca_pkg::REF_W + 1;

    fpca_pkg::seq_state_t state_reg, state_next;
    logic                 kind_reg, kind_next;
    fpca_pkg::item_size_t size_reg, size_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [ROOM_W-1:0]    loaded_reg, loaded_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    fpca_pkg::refused_t   refused_reg, refused_next;
    logic [ROOM_W-1:0]    free_reg, free_next;
    fpca_pkg::out_item_t  res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    fpca_pkg::out_item_t  m_data_reg, m_data_next;

    logic                 accept;
    logic [CNT_W-1:0]     cnt_inc;
    logic [ROOM_W-1:0]    size_room;
    logic                 load_full;
    logic [SUM_W-1:0]     ref_sum;
    logic [ROOM_W-1:0]    new_room;
    logic [ROOM_W-1:0]    others_max;
    logic [ROOM_W-1:0]    largest;

    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == fpca_pkg::S_IDLE);
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign size_room   = ROOM_W'(size_reg);
    assign size        = size_reg;
    assign start_idx   = (CNT_W'(rover_reg) < total_reg) ? rover_reg : '0;
    assign eval_idx    = eval_idx_reg;
    assign mem_rd_en   = (state_reg == fpca_pkg::S_SCAN);
    assign mem_rd_addr = cnt_reg[IDX_W-1:0];
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    always_comb begin
        scan_ctl.clear = accept;
        scan_ctl.eval  = eval_valid_reg;
    end

    // Decision datapath terms
    always_comb begin
        load_full = (total_reg >= CNT_W'(MAX_CHUNKS)) ||
                    (WIDE_W'(size_reg) > (WIDE_W'(BUFFER_BYTES) - WIDE_W'(loaded_reg)));
        ref_sum    = {1'b0, refused_reg} + SUM_W'(size_reg);
        new_room   = pick_room - size_room;
        others_max = (pick_idx == top1_idx) ? top2_room : top1_room;
    end

    // Next state and outputs
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        size_next       = size_reg;
        cnt_next        = cnt_reg;
        eval_valid_next = (state_reg == fpca_pkg::S_SCAN);
        eval_idx_next   = cnt_reg[IDX_W-1:0];
        total_next      = total_reg;
        loaded_next     = loaded_reg;
        rover_next      = rover_reg;
        refused_next    = refused_reg;
        free_next       = free_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = total_reg[IDX_W-1:0];
        mem_wr_data     = {loaded_reg, size_room};
        largest         = top1_room;

        case (state_reg)
            fpca_pkg::S_IDLE: begin
                if (accept) begin
                    kind_next  = s_data.kind;
                    size_next  = s_data.item_size;
                    cnt_next   = '0;
                    state_next = (total_reg != '0) ? fpca_pkg::S_SCAN : fpca_pkg::S_DECIDE;
                end
            end
            fpca_pkg::S_SCAN: begin
                cnt_next = cnt_inc;
                if (cnt_inc == total_reg) begin
                    state_next = fpca_pkg::S_DRAIN;
                end
            end
            fpca_pkg::S_DRAIN: begin
                // last entry is being compared this cycle
                state_next = fpca_pkg::S_DECIDE;
            end
            fpca_pkg::S_DECIDE: begin
                res_next.status      = fpca_pkg::ST_DONE;
                res_next.chunk_index = '0;
                res_next.byte_offset = '0;
                if (size_reg == '0) begin
                    res_next.status = fpca_pkg::ST_ZERO;
                end else if (kind_reg == fpca_pkg::KIND_LOAD) begin
                    if (load_full) begin
                        res_next.status = fpca_pkg::ST_FULL;
                    end else begin
                        // append a chunk at the end of the loaded bytes
                        mem_wr_en            = 1'b1;
                        res_next.chunk_index = fpca_pkg::chunk_index_t'(total_reg);
                        res_next.byte_offset = fpca_pkg::byte_offset_t'(loaded_reg);
                        loaded_next          = loaded_reg + size_room;
                        total_next           = cnt_inc - cnt_reg + total_reg;
                        free_next            = free_reg + size_room;
                        largest              = (size_room > top1_room) ? size_room : top1_room;
                    end
                end else if (!pick_found) begin
                    res_next.status = fpca_pkg::ST_NOFIT;
                    refused_next    = ref_sum[SUM_W-1] ? '1 : ref_sum[SUM_W-2:0];
                end else begin
                    // carve the request from the front of the chosen chunk
                    mem_wr_en            = 1'b1;
                    mem_wr_addr          = pick_idx;
                    mem_wr_data          = {pick_offset + size_room, new_room};
                    res_next.chunk_index = fpca_pkg::chunk_index_t'(pick_idx);
                    res_next.byte_offset = fpca_pkg::byte_offset_t'(pick_offset);
                    rover_next           = pick_idx;
                    free_next            = free_reg - size_room;
                    largest              = (new_room > others_max) ? new_room : others_max;
                end
                res_next.total_free    = fpca_pkg::free_t'(free_next);
                res_next.largest_free  = fpca_pkg::free_t'(largest);
                res_next.refused_total = refused_next;
                state_next             = fpca_pkg::S_RESULT;
            end
            fpca_pkg::S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = fpca_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fpca_pkg::S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fpca_pkg::S_IDLE;
            eval_valid_reg <= 1'b0;
            total_reg      <= '0;
            loaded_reg     <= '0;
            rover_reg      <= '0;
            refused_reg    <= '0;
            free_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            total_reg      <= total_next;
            loaded_reg     <= loaded_next;
            rover_reg      <= rover_next;
            refused_reg    <= refused_next;
            free_reg       <= free_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        size_reg     <= size_next;
        cnt_reg      <= cnt_next;
        eval_idx_reg <= eval_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

[rtl/fit_policy_chunk_allocator_unit.sv]
// Top level of the fit-policy chunk allocator.
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid, s_ready, s_data       | kind, item_size
//  result   | m_valid, m_ready, m_data       | status, index, offset, free, refused
//  config   | cfg_valid, cfg_ready, cfg_wdata| fit_policy
//
// Each item runs to completion before the next is accepted; the scan reads one
// table entry a cycle through the single memory read port and the shared
// compare unit, and an empty table skips the scan.
// Reset is synchronous and active low; the table needs no clearing pass.
// The result sits in its own register, so a stalled result only holds the
// next item in the final cycle of its work. Config writes are always taken.
`timescale 1ns / 1ps

module fit_policy_chunk_allocator_unit #(
    parameter int BUFFER_BYTES = fpca_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_CHUNKS   = fpca_pkg::MAX_CHUNKS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fpca_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fpca_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int ROOM_W = $clog2(BUFFER_BYTES + 1);

    fpca_pkg::policy_t    policy_reg;
    fpca_pkg::scan_ctl_t  scan_ctl;
    logic [IDX_W-1:0]     eval_idx;
    logic [IDX_W-1:0]     start_idx;
    fpca_pkg::item_size_t size;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_idx;
    logic [ROOM_W-1:0]    pick_room;
    logic [ROOM_W-1:0]    pick_offset;
    logic [ROOM_W-1:0]    top1_room;
    logic [IDX_W-1:0]     top1_idx;
    logic [ROOM_W-1:0]    top2_room;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [2*ROOM_W-1:0]  mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [2*ROOM_W-1:0]  mem_rd_data;

    // Policy register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= fpca_pkg::POLICY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            policy_reg <= fpca_pkg::policy_t'(cfg_wdata);
        end
    end

    fpca_seq #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_CHUNKS   (MAX_CHUNKS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .scan_ctl    (scan_ctl),
        .eval_idx    (eval_idx),
        .start_idx   (start_idx),
        .size        (size),
        .pick_found  (pick_found),
        .pick_idx    (pick_idx),
        .pick_room   (pick_room),
        .pick_offset (pick_offset),
        .top1_room   (top1_room),
        .top1_idx    (top1_idx),
        .top2_room   (top2_room),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    fpca_scan #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_CHUNKS   (MAX_CHUNKS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .policy      (policy_reg),
        .ctl         (scan_ctl),
        .eval_idx    (eval_idx),
        .start_idx   (start_idx),
        .eval_entry  (mem_rd_data),
        .size        (size),
        .pick_found  (pick_found),
        .pick_idx    (pick_idx),
        .pick_room   (pick_room),
        .pick_offset (pick_offset),
        .top1_room   (top1_room),
        .top1_idx    (top1_idx),
        .top2_room   (top2_room)
    );

    fpca_mem #(
        .DEPTH (MAX_CHUNKS),
        .WIDTH (2 * ROOM_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

[test/fpca_alloc_checker.sv]
// Result checker for the fit-policy chunk allocator: mirrors the chunk table and compares results.
`timescale 1ns / 1ps

module fpca_alloc_checker #(
    parameter int BUFFER_BYTES = fpca_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_CHUNKS   = fpca_pkg::MAX_CHUNKS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  fpca_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  fpca_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_wdata,
    output int                  fail_count,
    output int                  pending_count
);

    // Mirror of the allocator state
    fpca_pkg::policy_t   policy;
    logic [10:0]         next_off [MAX_CHUNKS];
    fpca_pkg::free_t     room [MAX_CHUNKS];
    int unsigned         n_chunks;
    int unsigned         bytes_loaded;
    int unsigned         rover;
    fpca_pkg::refused_t  refused;

    fpca_pkg::out_item_t alloc_results_due [$];
    fpca_pkg::out_item_t want;
    int                  mismatches;
    int unsigned         results_seen;

    // Applies one transaction to the mirrored table and returns the result it should produce
    function automatic fpca_pkg::out_item_t allocate(fpca_pkg::in_item_t it);
        fpca_pkg::out_item_t res;
        int unsigned         size;
        int                  pick;
        int unsigned         best;
        int unsigned         pos;
        int unsigned         left;
        int unsigned         total;
        fpca_pkg::free_t     largest;

        size    = it.item_size;
        res     = '0;
        res.status = fpca_pkg::ST_DONE;
        pick    = -1;
        best    = 0;
        total   = 0;
        largest = '0;

        if (size == 0) begin
            res.status = fpca_pkg::ST_ZERO;
        end else if (it.kind == fpca_pkg::KIND_LOAD) begin
            if (n_chunks >= MAX_CHUNKS || size > BUFFER_BYTES - bytes_loaded) begin
                res.status = fpca_pkg::ST_FULL;
            end else begin
                res.chunk_index      = fpca_pkg::chunk_index_t'(n_chunks);
                res.byte_offset      = fpca_pkg::byte_offset_t'(bytes_loaded);
                next_off[n_chunks]   = 11'(bytes_loaded);
                room[n_chunks]       = fpca_pkg::free_t'(size);
                bytes_loaded         = bytes_loaded + size;
                n_chunks             = n_chunks + 1;
            end
        end else begin
            if (policy == fpca_pkg::FIT_NEXT) begin
                // circular search from the last chunk used
                pos = (rover < n_chunks) ? rover : 0;
                for (int i = 0; i < n_chunks; i++) begin
                    if (room[pos] >= size) begin
                        pick = pos;
                        break;
                    end
                    pos = (pos + 1 >= n_chunks) ? 0 : pos + 1;
                end
            end else begin
                // linear scan; ties keep the lowest index
                for (int i = 0; i < n_chunks; i++) begin
                    if (room[i] >= size) begin
                        left = room[i] - size;
                        if (pick < 0 || (policy == fpca_pkg::FIT_BEST && left < best)
                            || (policy == fpca_pkg::FIT_WORST && left > best)) begin
                            pick = i;
                            best = left;
                        end
                        if (policy == fpca_pkg::FIT_FIRST) break;
                    end
                end
            end

            if (pick < 0) begin
                res.status = fpca_pkg::ST_NOFIT;
                refused = (refused > 32'hFFFF_FFFF - size) ? '1 : refused + size;
            end else begin
                res.chunk_index = fpca_pkg::chunk_index_t'(pick);
                res.byte_offset = fpca_pkg::byte_offset_t'(next_off[pick]);
                next_off[pick]  = 11'(next_off[pick] + size);
                room[pick]      = fpca_pkg::free_t'(room[pick] - size);
                rover           = pick;
            end
        end

        // free-space summary over the loaded chunks
        for (int i = 0; i < n_chunks; i++) begin
            total = total + room[i];
            if (room[i] > largest) largest = room[i];
        end
        res.total_free    = fpca_pkg::free_t'(total);
        res.largest_free  = largest;
        res.refused_total = refused;
        return res;
    endfunction

    // Track config writes, accepted items and returned results
    always @(posedge aclk) begin
        if (!aresetn) begin
            policy       = fpca_pkg::POLICY_RESET;
            n_chunks     = 0;
            bytes_loaded = 0;
            rover        = 0;
            refused      = '0;
            foreach (room[i]) begin
                room[i]     = '0;
                next_off[i] = '0;
            end
            alloc_results_due.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) policy = fpca_pkg::policy_t'(cfg_wdata);

            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (alloc_results_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no transaction outstanding",
                                 results_seen);
                end else begin
                    want = alloc_results_due.pop_front();
                    if (m_data.status !== want.status
                        || m_data.chunk_index !== want.chunk_index
                        || m_data.byte_offset !== want.byte_offset
                        || m_data.total_free !== want.total_free
                        || m_data.largest_free !== want.largest_free
                        || m_data.refused_total !== want.refused_total) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("result %0d expected st=%0d idx=%0d off=%0d",
                                     results_seen, want.status, want.chunk_index,
                                     want.byte_offset);
                            $display("  expected tot=%0d big=%0d ref=%0d",
                                     want.total_free, want.largest_free,
                                     want.refused_total);
                            $display("  got st=%0d idx=%0d off=%0d tot=%0d big=%0d ref=%0d",
                                     m_data.status, m_data.chunk_index,
                                     m_data.byte_offset, m_data.total_free,
                                     m_data.largest_free, m_data.refused_total);
                        end
                    end
                end
            end

            if (s_valid && s_ready) alloc_results_due.push_back(allocate(s_data));
        end
        fail_count    = mismatches;
        pending_count = alloc_results_due.size();
    end

endmodule

[test/testbench.sv]
// Testbench top for the fit-policy chunk allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned DRAIN_WAIT  = 80;
    localparam int unsigned LOAD_MAX    = 12;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    fpca_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    fpca_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_wdata = '0;

    int          fail_count;
    int          pending_count;

    // Idling controls for the sender and receiver; idle_enable is shared by both
    logic        idle_enable  = 1'b1;
    logic        hold_request = 1'b0;
    logic        hold_served  = 1'b0;
    int unsigned hold_cycles  = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;

    fit_policy_chunk_allocator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    fpca_alloc_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Request sizes stay small so the table's room lasts; the rest is edge values and noise
    function automatic int unsigned pick_size(logic kind);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (kind == fpca_pkg::KIND_LOAD) begin
            if (r < 85) return $urandom_range(1, LOAD_MAX);
            if (r < 93) return $urandom_range(0, 2047);
            if (r < 97) return 0;
            return $urandom_range(LOAD_MAX + 1, 300);
        end
        if (r < 80) return $urandom_range(1, 3);
        if (r < 90) return $urandom_range(4, 40);
        if (r < 97) return $urandom_range(0, 2047);
        return 0;
    endfunction

    // Result-side ready: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_request && !hold_served) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == LONG_HOLD) hold_served <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_enable && $urandom_range(0, 99) < 30) begin
            m_ready    <= 1'b0;
            stall_left <= rand_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one transaction; valid is left high when the next one follows at once
    task automatic push_item(input logic kind, input int unsigned size);
        int unsigned        gap;
        fpca_pkg::in_item_t item;
        item.kind      = kind;
        item.item_size = fpca_pkg::item_size_t'(size);
        s_valid        <= 1'b1;
        s_data         <= item;
        do @(posedge aclk); while (!s_ready);
        gap = idle_enable ? rand_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every outstanding result has returned
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_policy(input fpca_pkg::policy_t p);
        drain();
        cfg_valid <= 1'b1;
        cfg_wdata <= p;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input fpca_pkg::policy_t p, input int unsigned count,
                             input int unsigned load_pct);
        logic kind;
        write_policy(p);
        repeat (count) begin
            kind = ($urandom_range(0, 99) < load_pct) ? fpca_pkg::KIND_LOAD
                                                      : fpca_pkg::KIND_REQUEST;
            push_item(kind, pick_size(kind));
        end
    endtask

    // Stimulus
    initial begin
        fpca_pkg::policy_t phase_policy [7];

        phase_policy = '{fpca_pkg::FIT_NEXT, fpca_pkg::FIT_BEST, fpca_pkg::FIT_WORST,
                         fpca_pkg::FIT_FIRST, fpca_pkg::policy_t'($urandom_range(0, 3)),
                         fpca_pkg::FIT_BEST, fpca_pkg::FIT_NEXT};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Worst fit out of reset: empty table, zero sizes, overflow, exact fit
        push_item(fpca_pkg::KIND_REQUEST, 5);
        push_item(fpca_pkg::KIND_LOAD, 0);
        push_item(fpca_pkg::KIND_REQUEST, 0);
        push_item(fpca_pkg::KIND_LOAD, 2047);
        push_item(fpca_pkg::KIND_LOAD, 1025);
        push_item(fpca_pkg::KIND_LOAD, 10);
        push_item(fpca_pkg::KIND_LOAD, 20);
        push_item(fpca_pkg::KIND_LOAD, 5);
        push_item(fpca_pkg::KIND_LOAD, 30);
        push_item(fpca_pkg::KIND_REQUEST, 25);
        push_item(fpca_pkg::KIND_REQUEST, 20);
        push_item(fpca_pkg::KIND_REQUEST, 11);
        push_item(fpca_pkg::KIND_REQUEST, 2047);
        push_item(fpca_pkg::KIND_REQUEST, 1024);

        // First fit, down to an exact fit
        write_policy(fpca_pkg::FIT_FIRST);
        push_item(fpca_pkg::KIND_REQUEST, 4);
        push_item(fpca_pkg::KIND_REQUEST, 6);

        // Next fit, ending with a wrap past the last chunk
        write_policy(fpca_pkg::FIT_NEXT);
        push_item(fpca_pkg::KIND_REQUEST, 3);
        push_item(fpca_pkg::KIND_REQUEST, 4);
        push_item(fpca_pkg::KIND_REQUEST, 2);

        // Best fit with a tie between exact fits
        write_policy(fpca_pkg::FIT_BEST);
        push_item(fpca_pkg::KIND_LOAD, 8);
        push_item(fpca_pkg::KIND_LOAD, 3);
        push_item(fpca_pkg::KIND_REQUEST, 2);
        push_item(fpca_pkg::KIND_REQUEST, 1);

        write_policy(fpca_pkg::FIT_WORST);
        push_item(fpca_pkg::KIND_REQUEST, 1);

        // Fill the table to its chunk limit, then mostly requests
        run_phase(fpca_pkg::FIT_FIRST, 100, 80);
        for (int ph = 0; ph < 7; ph++) begin
            idle_enable <= (ph != 4);
            if (ph == 2) hold_request <= 1'b1;
            run_phase(phase_policy[ph], 146, 5);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
